>>> rtl/fpc_pkg.sv
`default_nettype none

package fpc_pkg;

    localparam int SET_W = 16;
    localparam int CNT_W = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(4096);
    localparam logic [SET_W-1:0] INAPPLICABLE_ONLY = SET_W'(1);

    localparam logic [SET_W-1:0] APP_MASK_RST = SET_W'(16'hFFFE);
    localparam logic [CNT_W-1:0] COST_LIMIT_RST = CNT_W'(4096);

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_DOWNPASS = 2'd0;
    localparam t_kind KIND_UPPASS = 2'd1;
    localparam t_kind KIND_TIP_UPPASS = 2'd2;
    localparam t_kind KIND_INSERT_COST = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_APP_MASK = 2'd0;
    localparam t_cfg_idx CFG_COST_LIMIT = 2'd1;

    typedef logic [SET_W-1:0] t_set;

    typedef struct packed {
        t_kind kind;
        t_set  left_set;
        t_set  right_set;
        t_set  node_prelim;
        t_set  anc_final;
        t_set  node_final;
        logic  last_char;
    } t_item;

    typedef struct packed {
        t_set result_set;
        logic step;
        logic changed;
    } t_set_res;

endpackage

`default_nettype wire

>>> rtl/fpc_set_logic.sv
`default_nettype none

module fpc_set_logic
    import fpc_pkg::*;
(
    input  var t_item    i_item,
    input  var t_set     i_app_mask,
    output var t_set_res o_res
);

    t_set l;
    t_set r;
    t_set p;
    t_set a;
    t_set f;
    t_set app;

    assign l   = i_item.left_set;
    assign r   = i_item.right_set;
    assign p   = i_item.node_prelim;
    assign a   = i_item.anc_final;
    assign f   = i_item.node_final;
    assign app = i_app_mask;

    always_comb begin
        o_res.result_set = '0;
        o_res.step       = 1'b0;
        o_res.changed    = 1'b0;
        unique case (i_item.kind)
            KIND_DOWNPASS: begin
                if (|(l & r)) begin
                    o_res.result_set = l & r;
                end else if (|(l & app) && |(r & app)) begin
                    o_res.result_set = (l | r) & app;
                    o_res.step       = 1'b1;
                end else begin
                    o_res.result_set = l | r;
                end
            end
            KIND_UPPASS: begin
                if ((p & a) == a) begin
                    o_res.result_set = p & a;
                end else if (|(l & r)) begin
                    o_res.result_set = p | (a & (l | r));
                end else if (|(a & app) && |(p & app)) begin
                    o_res.result_set = (p | a) & app;
                end else begin
                    o_res.result_set = p | a;
                end
                o_res.changed = (o_res.result_set != f);
            end
            KIND_TIP_UPPASS: begin
                if ((p != INAPPLICABLE_ONLY) && |(p & a)) begin
                    o_res.result_set = p & a;
                end else begin
                    o_res.result_set = f;
                end
                o_res.changed = (o_res.result_set != f);
            end
            KIND_INSERT_COST: begin
                o_res.step = ~|(f & (l | r));
            end
            default: begin
                o_res.result_set = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/fpc_step_counter.sv
`default_nettype none

module fpc_step_counter
    import fpc_pkg::*;
(
    input  var logic             i_clk,
    input  var logic             i_rst_n,
    input  var logic             i_advance,
    input  var logic             i_step,
    input  var logic             i_last_char,
    input  var logic [CNT_W-1:0] i_cost_limit,
    output var logic [CNT_W-1:0] o_count,
    output var logic             o_over_limit
);

    logic [CNT_W-1:0] r_running;
    logic [CNT_W-1:0] n_running;
    logic [CNT_W:0]   sum;

    assign sum = {1'b0, r_running} + {{CNT_W{1'b0}}, i_step};

    always_comb begin
        if (sum > {1'b0, COUNT_CAP}) begin
            o_count = COUNT_CAP;
        end else begin
            o_count = sum[CNT_W-1:0];
        end
    end

    assign o_over_limit = (o_count > i_cost_limit);
    assign n_running    = i_last_char ? '0 : o_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
        end else if (i_advance) begin
            r_running <= n_running;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fitch_parsimony_character_unit.sv
// Fitch parsimony character unit with inapplicable states. One character of
// one node enters per word on the input channel and one result word leaves
// for each. The unit takes one word per clock while the receiver does not
// stall: a word is registered in the input register at accept, evaluated
// combinationally from that register and captured in the output register
// as the unit advances, and is offered from there. The running step count
// moves forward as each word reaches the output register and restarts after
// a word marked as last character. Configuration writes are taken in every
// cycle and must only be issued while the unit is empty.
`default_nettype none

module fitch_parsimony_character_unit
    import fpc_pkg::*;
(
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    input  var logic                  i_valid,
    output var logic                  o_ready,
    input  var logic [1:0]            i_kind,
    input  var logic [SET_W-1:0]      i_left_set,
    input  var logic [SET_W-1:0]      i_right_set,
    input  var logic [SET_W-1:0]      i_node_prelim,
    input  var logic [SET_W-1:0]      i_anc_final,
    input  var logic [SET_W-1:0]      i_node_final,
    input  var logic                  i_last_char,
    output var logic                  o_valid,
    input  var logic                  i_ready,
    output var logic [SET_W-1:0]      o_result_set,
    output var logic                  o_step,
    output var logic [CNT_W-1:0]      o_step_count,
    output var logic                  o_over_limit,
    output var logic                  o_changed,
    input  var logic                  i_cfg_valid,
    output var logic                  o_cfg_ready,
    input  var logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  var logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_set             r_app_mask;
    logic [CNT_W-1:0] r_cost_limit;

    logic             r_in_valid;
    t_item            r_item;

    logic             r_out_valid;
    t_set             r_result_set;
    logic             r_step;
    logic [CNT_W-1:0] r_step_count;
    logic             r_over_limit;
    logic             r_changed;

    logic             advance;
    t_set_res         set_res;
    logic [CNT_W-1:0] count;
    logic             over_limit;

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app_mask   <= APP_MASK_RST;
            r_cost_limit <= COST_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_APP_MASK) begin
                r_app_mask <= i_cfg_data[SET_W-1:0];
            end else if (i_cfg_index == CFG_COST_LIMIT) begin
                r_cost_limit <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    // input register
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.kind        <= i_kind;
            r_item.left_set    <= i_left_set;
            r_item.right_set   <= i_right_set;
            r_item.node_prelim <= i_node_prelim;
            r_item.anc_final   <= i_anc_final;
            r_item.node_final  <= i_node_final;
            r_item.last_char   <= i_last_char;
        end
    end

    fpc_set_logic u_set_logic (
        .i_item     (r_item),
        .i_app_mask (r_app_mask),
        .o_res      (set_res)
    );

    fpc_step_counter u_step_counter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_step       (set_res.step),
        .i_last_char  (r_item.last_char),
        .i_cost_limit (r_cost_limit),
        .o_count      (count),
        .o_over_limit (over_limit)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result_set <= set_res.result_set;
            r_step       <= set_res.step;
            r_step_count <= count;
            r_over_limit <= over_limit;
            r_changed    <= set_res.changed;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_result_set = r_result_set;
    assign o_step       = r_step;
    assign o_step_count = r_step_count;
    assign o_over_limit = r_over_limit;
    assign o_changed    = r_changed;

endmodule

`default_nettype wire

>>> sim/tb_fitch_parsimony_character_unit.sv
module tb_fitch_parsimony_character_unit
    import fpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_set             set_v;
        logic             step;
        logic [CNT_W-1:0] count;
        logic             over;
        logic             changed;
    } t_char_word;

    class char_result_board;
        t_set             app_mask;
        logic [CNT_W-1:0] cost_limit;
        logic [CNT_W-1:0] run_steps;
        t_char_word       expected_words[$];
        int               mismatches;

        function new();
            app_mask   = APP_MASK_RST;
            cost_limit = COST_LIMIT_RST;
            run_steps  = '0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_APP_MASK:   app_mask = d;
                CFG_COST_LIMIT: cost_limit = d[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // fitch rules with inapplicable bit zero, then the running step count
        function void note_item(t_item it);
            t_char_word w;
            t_set       l;
            t_set       r;
            t_set       p;
            t_set       a;
            t_set       f;
            int         total;
            l = it.left_set;
            r = it.right_set;
            p = it.node_prelim;
            a = it.anc_final;
            f = it.node_final;
            w = '0;
            case (it.kind)
                KIND_DOWNPASS: begin
                    if ((l & r) != '0) begin
                        w.set_v = l & r;
                    end else begin
                        w.set_v = l | r;
                        if ((l & app_mask) != '0 && (r & app_mask) != '0) begin
                            w.set_v = w.set_v & app_mask;
                            w.step  = 1'b1;
                        end
                    end
                end
                KIND_UPPASS: begin
                    if ((p & a) == a)
                        w.set_v = p & a;
                    else if ((l & r) != '0)
                        w.set_v = p | (a & (l | r));
                    else if ((a & app_mask) != '0 && (p & app_mask) != '0)
                        w.set_v = (p | a) & app_mask;
                    else
                        w.set_v = p | a;
                    w.changed = (w.set_v != f);
                end
                KIND_TIP_UPPASS: begin
                    w.set_v = f;
                    if (p != INAPPLICABLE_ONLY && (p & a) != '0)
                        w.set_v = p & a;
                    w.changed = (w.set_v != f);
                end
                default: begin
                    w.step = ((f & (l | r)) == '0);
                end
            endcase
            total = int'(run_steps) + int'(w.step);
            if (total > int'(COUNT_CAP))
                total = int'(COUNT_CAP);
            w.count   = total[CNT_W-1:0];
            w.over    = (total > int'(cost_limit));
            run_steps = it.last_char ? '0 : total[CNT_W-1:0];
            expected_words.push_back(w);
        endfunction

        function void check_result(t_char_word got);
            t_char_word want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: set %h step %0d count %0d over %0d changed %0d",
                             got.set_v, got.step, got.count, got.over, got.changed);
                return;
            end
            want = expected_words.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp set %h step %0d count %0d over %0d changed %0d",
                             want.set_v, want.step, want.count, want.over, want.changed);
                    $display("          got set %h step %0d count %0d over %0d changed %0d",
                             got.set_v, got.step, got.count, got.over, got.changed);
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_kind        = '0;
    logic [SET_W-1:0]      i_left_set    = '0;
    logic [SET_W-1:0]      i_right_set   = '0;
    logic [SET_W-1:0]      i_node_prelim = '0;
    logic [SET_W-1:0]      i_anc_final   = '0;
    logic [SET_W-1:0]      i_node_final  = '0;
    logic                  i_last_char   = 1'b0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [SET_W-1:0]      o_result_set;
    logic                  o_step;
    logic [CNT_W-1:0]      o_step_count;
    logic                  o_over_limit;
    logic                  o_changed;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    char_result_board board;
    logic [1:0]       rdy_mode  = 2'd0;
    logic [15:0]      stall_pat = 16'hB38F;
    bit               gaps_on   = 1'b0;
    int               burst_left = 0;

    fitch_parsimony_character_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_left_set   (i_left_set),
        .i_right_set  (i_right_set),
        .i_node_prelim(i_node_prelim),
        .i_anc_final  (i_anc_final),
        .i_node_final (i_node_final),
        .i_last_char  (i_last_char),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result_set (o_result_set),
        .o_step       (o_step),
        .o_step_count (o_step_count),
        .o_over_limit (o_over_limit),
        .o_changed    (o_changed),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver stall patterns
    always @(posedge i_clk) begin
        case (rdy_mode)
            2'd0: i_ready <= 1'b1;
            2'd1: i_ready <= ($urandom_range(0, 3) != 0);
            2'd2: begin
                i_ready   <= stall_pat[0];
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
            end
            default: i_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result('{set_v: o_result_set, step: o_step, count: o_step_count,
                                 over: o_over_limit, changed: o_changed});
    end

    function automatic t_item make_item(t_kind k, t_set l, t_set r, t_set p, t_set a,
                                        t_set f, logic last);
        t_item it;
        it.kind        = k;
        it.left_set    = l;
        it.right_set   = r;
        it.node_prelim = p;
        it.anc_final   = a;
        it.node_final  = f;
        it.last_char   = last;
        return it;
    endfunction

    function automatic t_set rand_set();
        t_set s;
        case ($urandom_range(0, 9))
            0: s = INAPPLICABLE_ONLY;
            1: s = t_set'(1) << $urandom_range(1, 15);
            2: s = (t_set'(1) << $urandom_range(1, 15)) | t_set'($urandom_range(0, 1));
            3: s = t_set'($urandom);
            4: s = '1;
            5: s = '0;
            default: s = t_set'($urandom_range(1, 31));
        endcase
        return s;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.kind        = t_kind'($urandom_range(0, 3));
        it.left_set    = rand_set();
        it.right_set   = rand_set();
        it.node_prelim = rand_set();
        it.anc_final   = rand_set();
        it.node_final  = rand_set();
        it.last_char   = ($urandom_range(0, 24) == 0);
        if (it.kind == KIND_UPPASS && $urandom_range(0, 3) == 0)
            it.anc_final = it.node_prelim & t_set'($urandom);
        if (it.kind != KIND_DOWNPASS && $urandom_range(0, 3) == 0)
            it.node_final = it.node_prelim & it.anc_final;
        if (it.kind == KIND_INSERT_COST && $urandom_range(0, 2) == 0)
            it.node_final = it.left_set | rand_set();
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int idle;
        if (gaps_on) begin
            if (burst_left == 0) begin
                idle       = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                i_valid <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            burst_left--;
        end
        i_valid       <= 1'b1;
        i_kind        <= it.kind;
        i_left_set    <= it.left_set;
        i_right_set   <= it.right_set;
        i_node_prelim <= it.node_prelim;
        i_anc_final   <= it.anc_final;
        i_node_final  <= it.node_final;
        i_last_char   <= it.last_char;
        do @(posedge i_clk); while (!o_ready);
        board.note_item(it);
    endtask

    task automatic drain_words();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // leaves the config valid high so back to back writes never toggle it
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, d);
    endtask

    task automatic configure(input logic [15:0] mask_w, input logic [15:0] limit_w,
                             input bit poke_unknown);
        write_reg(CFG_APP_MASK, mask_w);
        write_reg(CFG_COST_LIMIT, limit_w);
        if (poke_unknown) begin
            write_reg(t_cfg_idx'(2), 16'($urandom));
            write_reg(t_cfg_idx'(3), 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] mask_w, input logic [15:0] limit_w,
                             input bit poke_unknown, input logic [1:0] mode,
                             input bit gaps, input int n, input bit mid_pause);
        drain_words();
        configure(mask_w, limit_w, poke_unknown);
        rdy_mode <= mode;
        gaps_on    = gaps;
        burst_left = 0;
        for (int i = 0; i < n; i++) begin
            if (mid_pause && i == n / 2)
                drain_words();
            send_item(rand_item());
        end
    endtask

    initial begin
        t_item directed[$];
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: fitch branches, tip corner cases, field extremes
        directed.push_back(make_item(KIND_DOWNPASS, 16'h0006, 16'h0004, '0, '0, '0, 1'b0));
        directed.push_back(make_item(KIND_DOWNPASS, 16'h0002, 16'h0008, '0, '0, '0, 1'b0));
        directed.push_back(make_item(KIND_DOWNPASS, 16'h0001, 16'h0004, '0, '0, '0, 1'b0));
        directed.push_back(make_item(KIND_DOWNPASS, 16'h0003, 16'h000C, '0, '0, '0, 1'b0));
        directed.push_back(make_item(KIND_DOWNPASS, 16'h0000, 16'h0000, '0, '0, '0, 1'b0));
        directed.push_back(make_item(KIND_DOWNPASS, '1, '1, '1, '1, '1, 1'b1));
        directed.push_back(make_item(KIND_UPPASS, '0, '0, 16'h000E, 16'h0006, 16'h0006,
                                     1'b0));
        directed.push_back(make_item(KIND_UPPASS, 16'h0004, 16'h0006, 16'h0002, 16'h000C,
                                     16'h0002, 1'b0));
        directed.push_back(make_item(KIND_UPPASS, 16'h0002, 16'h0008, 16'h0002, 16'h000C,
                                     16'h000E, 1'b0));
        directed.push_back(make_item(KIND_UPPASS, 16'h0002, 16'h0008, 16'h0001, 16'h000C,
                                     16'h0001, 1'b0));
        directed.push_back(make_item(KIND_TIP_UPPASS, '0, '0, 16'h0001, 16'h0003, 16'h0010,
                                     1'b0));
        directed.push_back(make_item(KIND_TIP_UPPASS, '0, '0, 16'h0006, 16'h0018, 16'h0006,
                                     1'b0));
        directed.push_back(make_item(KIND_TIP_UPPASS, '0, '0, 16'h0006, 16'h0004, 16'h0006,
                                     1'b0));
        directed.push_back(make_item(KIND_INSERT_COST, 16'h0002, 16'h0004, '0, '0, 16'h0008,
                                     1'b0));
        directed.push_back(make_item(KIND_INSERT_COST, 16'h0002, 16'h0004, '0, '0, 16'h0004,
                                     1'b0));
        directed.push_back(make_item(KIND_INSERT_COST, '0, '0, '0, '0, '0, 1'b1));
        directed.push_back(make_item(KIND_UPPASS, '1, '1, '1, '1, '1, 1'b0));
        directed.push_back(make_item(KIND_TIP_UPPASS, '1, '1, '1, '1, '1, 1'b0));
        directed.push_back(make_item(KIND_UPPASS, '0, '0, '0, '0, '0, 1'b0));
        directed.push_back(make_item(KIND_TIP_UPPASS, '0, '0, '0, '0, '0, 1'b0));
        directed.push_back(make_item(KIND_INSERT_COST, '1, '1, '1, '1, '1, 1'b1));
        foreach (directed[i])
            send_item(directed[i]);

        run_phase(16'hFFFF, 16'd0, 1'b0, 2'd1, 1'b1, 166, 1'b1);
        run_phase(16'h0000, 16'd5, 1'b0, 2'd2, 1'b1, 166, 1'b0);
        run_phase(16'($urandom), 16'($urandom_range(0, 4096)), 1'b1, 2'd3, 1'b1, 166, 1'b1);
        run_phase(16'hFFFE, 16'hFFFF, 1'b0, 2'd0, 1'b0, 166, 1'b0);
        run_phase(16'hFFFE, 16'd4096, 1'b1, 2'd1, 1'b1, 166, 1'b0);

        drain_words();
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/fpc_pkg.sv
rtl/fpc_set_logic.sv
rtl/fpc_step_counter.sv
rtl/fitch_parsimony_character_unit.sv
sim/tb_fitch_parsimony_character_unit.sv
